// ===== rtl/triangular_mel_band_energy_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TRIANGULAR_MEL_BAND_ENERGY_MACROS_SVH
`define TRIANGULAR_MEL_BAND_ENERGY_MACROS_SVH

// Check cons in the cycle after ante.
`define TMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cons in the same cycle as ante.
`define TMBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tmbe_pkg.sv =====
package tmbe_pkg;

	localparam int BINS             = 512;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int BIN_W    = $clog2(BINS + 1);
	localparam int KW       = 16;
	localparam int RATE_W   = 18;
	localparam int HZ_W     = 17;
	localparam int MAG_W    = 32;
	localparam int SUM_W    = 63;
	localparam int DIV_W    = HZ_W + BIN_W;
	localparam int FR_W     = KW + RATE_W;
	localparam int FREQ_W   = (FR_W > DIV_W) ? FR_W : DIV_W;
	localparam int QW       = (DIV_W > WEIGHT_FRAC_BITS) ? DIV_W : WEIGHT_FRAC_BITS;
	localparam int STEP_W   = $clog2(QW + 1);
	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;
	localparam int PROD_W   = MAG_W + WEIGHT_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RATE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = CFG_IDX_W'(3);

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

	localparam logic [STEP_W-1:0] STEPS_LIM    = STEP_W'(DIV_W);
	localparam logic [STEP_W-1:0] STEPS_WEIGHT = STEP_W'(WEIGHT_FRAC_BITS);

	typedef struct packed {
		logic signed [MAG_W-1:0] bin_value;
		logic                    last_bin;
	} in_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] band_energy;
		logic             saturated;
	} out_word_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [HZ_W-1:0]   lower;
		logic [HZ_W-1:0]   center;
		logic [HZ_W-1:0]   upper;
		logic              upd;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/triangular_mel_band_energy.sv =====
// Triangular band energy: one bin word per item, weighted by a triangle over linear frequency
// and summed into a saturating Q.16 accumulator; a word with last_bin set emits the sum on the
// output channel and clears the frame. One bin at a time is in work and in_stall stays high
// meanwhile. A bin that falls inside a slope goes through accept, decide, WEIGHT_FRAC_BITS
// steps of the shared restoring divider (one quotient bit per cycle), taking the quotient,
// multiply and accumulate. A bin of zero weight or at the peak skips the divider. The first
// bin after any register write first finds the band limit bins with the same divider. A
// finished result waits in the output register while the next bins are taken; a last bin
// holds only if that register is still full.
module triangular_mel_band_energy (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tmbe_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tmbe_pkg::out_word_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int DW  = tmbe_pkg::DIV_W;
	localparam int FW  = tmbe_pkg::FREQ_W;
	localparam int WF  = tmbe_pkg::WEIGHT_FRAC_BITS;
	localparam int SW  = tmbe_pkg::SUM_W;

	localparam logic [DW-1:0] BINS_N  = DW'(tmbe_pkg::BINS);
	localparam logic [DW-1:0] BIN_MAX = DW'(tmbe_pkg::BINS - 1);
	localparam logic [tmbe_pkg::WEIGHT_W-1:0] W_PEAK = {1'b1, {WF{1'b0}}};

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LIM_LO = 3'd1;
	localparam logic [2:0] S_LIM_HI = 3'd2;
	localparam logic [2:0] S_DEC    = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_MULW   = 3'd5;
	localparam logic [2:0] S_ACC    = 3'd6;

	tmbe_pkg::cfg_t     cfg;
	tmbe_pkg::div_req_t req;
	tmbe_pkg::div_rsp_t rsp;

	logic [2:0]                    state_q;
	logic                          lim_ok_q;
	logic [tmbe_pkg::KW-1:0]       bin_counter_q;
	logic [SW-1:0]                 sum_q;
	logic                          clip_q;
	logic                          out_valid_q;
	tmbe_pkg::out_word_t           out_q;

	logic [FW-1:0]                 f_q;
	logic [tmbe_pkg::MAG_W-1:0]    mag_q;
	logic                          last_q;
	logic [DW-1:0]                 lo_q;
	logic [DW-1:0]                 hi_q;
	logic [tmbe_pkg::WEIGHT_W-1:0] w_q;
	logic [tmbe_pkg::PROD_W-1:0]   prod_q;

	logic                          accept;
	logic [tmbe_pkg::MAG_W-1:0]    raw;
	logic [tmbe_pkg::MAG_W-1:0]    mag;
	logic [tmbe_pkg::FR_W-1:0]     f_raw;
	logic [FW-1:0]                 lon;
	logic [FW-1:0]                 cen;
	logic [FW-1:0]                 upn;
	logic [DW-1:0]                 kx;
	logic [DW-1:0]                 hu;
	logic                          w_zero;
	logic                          rise;
	logic                          fall;
	logic                          peak;
	logic [DW-1:0]                 a_num;
	logic [DW-1:0]                 d_den;
	logic                          need_div;
	logic [SW:0]                   sum_n;
	logic                          sat;
	logic                          out_block;

	tmbe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tmbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign raw   = in_data.bin_value;
	assign mag   = raw[tmbe_pkg::MAG_W-1] ? (~raw + tmbe_pkg::MAG_W'(1)) : raw;
	assign f_raw = tmbe_pkg::FR_W'(bin_counter_q) * tmbe_pkg::FR_W'(cfg.rate);

	assign lon = FW'(cfg.lower) * FW'(tmbe_pkg::BINS);
	assign cen = FW'(cfg.center) * FW'(tmbe_pkg::BINS);
	assign upn = FW'(cfg.upper) * FW'(tmbe_pkg::BINS);
	assign kx  = DW'(bin_counter_q);
	assign hu  = rsp.quo[DW-1:0];

	always_comb begin
		w_zero = (cfg.rate == '0) || (hi_q <= lo_q) || (kx < lo_q) || (kx > hi_q)
			|| (f_q < lon);
		rise   = (f_q < cen);
		fall   = ~rise && (f_q < upn);
		if (rise) begin
			a_num = DW'(f_q - lon);
			d_den = DW'(cen - lon);
		end else begin
			a_num = DW'(upn - f_q);
			d_den = DW'(upn - cen);
		end
		peak     = fall && (a_num == d_den);
		need_div = ~w_zero && (rise || (fall && ~peak));
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && !lim_ok_q) begin
					req.start    = 1'b1;
					req.dividend = DW'(cfg.lower) * BINS_N;
					req.divisor  = DW'(cfg.rate);
					req.steps    = tmbe_pkg::STEPS_LIM;
				end
			end
			S_LIM_LO: begin
				if (rsp.done) begin
					req.start    = 1'b1;
					req.dividend = DW'(cfg.upper) * BINS_N;
					req.divisor  = DW'(cfg.rate);
					req.steps    = tmbe_pkg::STEPS_LIM;
				end
			end
			S_DEC: begin
				if (need_div) begin
					req.start    = 1'b1;
					req.rem_init = a_num;
					req.divisor  = d_den;
					req.steps    = tmbe_pkg::STEPS_WEIGHT;
				end
			end
			default: ;
		endcase
	end

	assign sum_n     = {1'b0, sum_q} + (SW + 1)'(prod_q);
	assign sat       = sum_n[SW];
	assign out_block = last_q & out_valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			lim_ok_q      <= 1'b0;
			bin_counter_q <= '0;
			sum_q         <= '0;
			clip_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.upd) begin
				lim_ok_q <= 1'b0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= lim_ok_q ? S_DEC : S_LIM_LO;
					end
				end
				S_LIM_LO: begin
					if (rsp.done) begin
						state_q <= S_LIM_HI;
					end
				end
				S_LIM_HI: begin
					if (rsp.done) begin
						lim_ok_q <= 1'b1;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= need_div ? S_DIV : S_MULW;
				end
				S_DIV: begin
					if (rsp.done) begin
						state_q <= S_MULW;
					end
				end
				S_MULW: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!out_block) begin
						state_q <= S_IDLE;
						if (last_q) begin
							out_valid_q   <= 1'b1;
							sum_q         <= '0;
							clip_q        <= 1'b0;
							bin_counter_q <= '0;
						end else begin
							sum_q         <= sat ? tmbe_pkg::SUM_MAX : sum_n[SW-1:0];
							clip_q        <= clip_q | sat;
							bin_counter_q <= bin_counter_q + tmbe_pkg::KW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_q    <= FW'(f_raw);
			mag_q  <= mag;
			last_q <= in_data.last_bin;
		end
		if (state_q == S_LIM_LO && rsp.done) begin
			lo_q <= hu;
		end
		if (state_q == S_LIM_HI && rsp.done) begin
			hi_q <= (hu > BIN_MAX) ? BIN_MAX : hu;
		end
		if (state_q == S_DEC) begin
			w_q <= (w_zero || !(rise || fall)) ? '0 : W_PEAK;
		end
		if (state_q == S_DIV && rsp.done) begin
			w_q <= {1'b0, rsp.quo[WF-1:0]};
		end
		if (state_q == S_MULW) begin
			prod_q <= tmbe_pkg::PROD_W'(mag_q) * tmbe_pkg::PROD_W'(w_q);
		end
		if (state_q == S_ACC && last_q && !out_block) begin
			out_q.band_energy <= sat ? tmbe_pkg::SUM_MAX : sum_n[SW-1:0];
			out_q.saturated   <= clip_q | sat;
		end
	end

endmodule

// ===== rtl/tmbe_cfg.sv =====
module tmbe_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmbe_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tmbe_pkg::cfg_t                   cfg
);

	logic [tmbe_pkg::RATE_W-1:0] rate_q;
	logic [tmbe_pkg::HZ_W-1:0]   lower_q;
	logic [tmbe_pkg::HZ_W-1:0]   center_q;
	logic [tmbe_pkg::HZ_W-1:0]   upper_q;
	logic                        wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= tmbe_pkg::RATE_RESET;
			lower_q  <= '0;
			center_q <= '0;
			upper_q  <= '0;
		end else if (wr) begin
			case (cfg_index)
				tmbe_pkg::CFG_RATE:   rate_q   <= cfg_data[tmbe_pkg::RATE_W-1:0];
				tmbe_pkg::CFG_LOWER:  lower_q  <= cfg_data[tmbe_pkg::HZ_W-1:0];
				tmbe_pkg::CFG_CENTER: center_q <= cfg_data[tmbe_pkg::HZ_W-1:0];
				tmbe_pkg::CFG_UPPER:  upper_q  <= cfg_data[tmbe_pkg::HZ_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.rate   = rate_q;
	assign cfg.lower  = lower_q;
	assign cfg.center = center_q;
	assign cfg.upper  = upper_q;
	assign cfg.upd    = wr;

endmodule

// ===== rtl/tmbe_div.sv =====
module tmbe_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmbe_pkg::div_req_t   req,
	output tmbe_pkg::div_rsp_t   rsp
);

	localparam int DW = tmbe_pkg::DIV_W;
	localparam int QW = tmbe_pkg::QW;

	logic                        busy_q;
	logic                        done_q;
	logic [tmbe_pkg::STEP_W-1:0] cnt_q;
	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               num_q;
	logic [DW-1:0]               dvs_q;
	logic [QW-1:0]               quo_q;
	logic [DW:0]                 trial;
	logic                        ge;
	logic [DW-1:0]               rem_n;

	assign trial = {rem_q, num_q[DW-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign rem_n = ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - tmbe_pkg::STEP_W'(1);
				if (cnt_q == tmbe_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			num_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			num_q <= {num_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/tmbe_checker.sv =====
`include "triangular_mel_band_energy_macros.svh"

module tmbe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input tmbe_pkg::out_word_t out_data
);

	`TMBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result word changed")
	`TMBE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accepting a word")
	`TMBE_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result word appeared one cycle after accept")
	`TMBE_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result word appeared while idle")

endmodule

bind triangular_mel_band_energy tmbe_checker u_tmbe_checker (.*);
